// ----- rtl/opwbr_pkg.sv -----
`default_nettype none

package opwbr_pkg;

	localparam int BITS_PER_DIGIT = 4;
	localparam int COUNT_BITS = 3;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [1:0] REG_DARK_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_MIN_PULSE = 2'd1;
	localparam logic [1:0] REG_BIT_BOUNDARY = 2'd2;
	localparam logic [1:0] REG_MAX_PULSE = 2'd3;

	localparam logic [9:0] RESET_DARK_THRESHOLD = 10'd300;
	localparam logic [15:0] RESET_MIN_PULSE = 16'd10;
	localparam logic [15:0] RESET_BIT_BOUNDARY = 16'd2500;
	localparam logic [15:0] RESET_MAX_PULSE = 16'd5000;

	localparam logic [3:0] MAX_BCD = 4'd9;

	typedef struct packed {
		logic [9:0] dark_threshold;
		logic [15:0] min_pulse_ms;
		logic [15:0] bit_boundary_ms;
		logic [15:0] max_pulse_ms;
	} cfg_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

endpackage

`default_nettype wire

// ----- rtl/opwbr_front.sv -----
`default_nettype none

module opwbr_front #(
	parameter int TIME_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire opwbr_pkg::cfg_t cfg,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [9:0] sample_level,
	input wire logic [TIME_BITS-1:0] time_ms,
	input wire opwbr_pkg::queue_stat_t qstat,
	output logic push,
	output logic push_bit
);
	import opwbr_pkg::*;

	logic [TIME_BITS-1:0] last_dark_q;
	logic [TIME_BITS-1:0] last_lit_q;
	logic [TIME_BITS-1:0] run_start_q;
	logic [TIME_BITS-1:0] run_len;
	logic take;
	logic lit;
	logic is_zero;
	logic is_one;

	assign in_ready = !qstat.full;
	assign take = in_valid && in_ready;
	assign lit = sample_level > cfg.dark_threshold;
	assign run_len = last_lit_q - run_start_q;

	assign is_zero = (run_len > TIME_BITS'(cfg.min_pulse_ms)) &&
		(run_len <= TIME_BITS'(cfg.bit_boundary_ms));
	assign is_one = (run_len > TIME_BITS'(cfg.bit_boundary_ms)) &&
		(run_len <= TIME_BITS'(cfg.max_pulse_ms));

	assign push = take && !lit && (is_zero || is_one);
	assign push_bit = !is_zero;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_dark_q <= '0;
			last_lit_q <= '0;
			run_start_q <= '0;
		end else if (take) begin
			if (lit) begin
				last_lit_q <= time_ms;
				run_start_q <= last_dark_q;
			end else begin
				last_dark_q <= time_ms;
				last_lit_q <= '0;
				run_start_q <= '0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/opwbr_queue.sv -----
`default_nettype none

module opwbr_queue (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire logic push_bit,
	input wire logic pop,
	output logic pop_bit,
	output opwbr_pkg::queue_stat_t qstat
);
	import opwbr_pkg::*;

	logic data_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QPTR_BITS:0] count_q;
	logic do_push;
	logic do_pop;

	assign qstat.full = count_q == (QPTR_BITS+1)'(QUEUE_DEPTH);
	assign qstat.empty = count_q == '0;
	assign do_push = push && !qstat.full;
	assign do_pop = pop && !qstat.empty;
	assign pop_bit = data_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			data_q[wr_ptr_q] <= push_bit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/opwbr_back.sv -----
`default_nettype none

module opwbr_back (
	input wire logic clk,
	input wire logic arst_n,
	input wire opwbr_pkg::queue_stat_t qstat,
	input wire logic pop_bit,
	output logic pop,
	output logic out_valid,
	input wire logic out_ready,
	output logic bit_value,
	output logic digit_done,
	output logic digit_valid,
	output logic [3:0] digit_value,
	output logic sum_done,
	output logic [4:0] pair_sum
);
	import opwbr_pkg::*;

	logic [3:0] bit_shift_q;
	logic [COUNT_BITS-1:0] bit_count_q;
	logic [3:0] first_digit_q;
	logic first_held_q;
	logic out_valid_q;
	logic [3:0] shift_n;
	logic [COUNT_BITS-1:0] count_n;
	logic group_end;
	logic bcd_ok;
	logic [4:0] sum_n;

	assign pop = !qstat.empty && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	assign shift_n = {bit_shift_q[2:0], pop_bit};
	assign count_n = bit_count_q + 1'b1;
	assign group_end = count_n == COUNT_BITS'(BITS_PER_DIGIT);
	assign bcd_ok = shift_n <= MAX_BCD;
	assign sum_n = {1'b0, first_digit_q} + {1'b0, shift_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_shift_q <= '0;
			bit_count_q <= '0;
			first_digit_q <= '0;
			first_held_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				out_valid_q <= 1'b1;
				bit_shift_q <= shift_n;
				bit_count_q <= group_end ? '0 : count_n;
				if (group_end && bcd_ok) begin
					if (first_held_q) begin
						first_held_q <= 1'b0;
						first_digit_q <= '0;
					end else begin
						first_held_q <= 1'b1;
						first_digit_q <= shift_n;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bit_value <= pop_bit;
			digit_done <= group_end;
			digit_valid <= group_end && bcd_ok;
			digit_value <= (group_end && bcd_ok) ? shift_n : '0;
			sum_done <= group_end && bcd_ok && first_held_q;
			pair_sum <= (group_end && bcd_ok && first_held_q) ? sum_n : '0;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/optical_pulse_width_bcd_receiver.sv -----
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_ready     sample_level, time_ms
// result    out        out_valid / out_ready   bit_value, digit_done, digit_valid,
//                                              digit_value, sum_done, pair_sum
// config    in         cfg_we                  cfg_index, cfg_data
//
// One sample is taken per cycle while in_ready is high; a decoded bit is pushed into the
// queue when its dark sample is transferred. The front stage measures the run and
// classifies it, and a two-entry queue hands bits to the back stage that builds digits
// and pair sums into the output register. A stalled output fills the queue, after which
// in_ready drops. Reset is asynchronous and clears all timing, digit and pairing state.
`default_nettype none

module optical_pulse_width_bcd_receiver #(
	parameter int TIME_BITS = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [15:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [9:0] sample_level,
	input wire logic [TIME_BITS-1:0] time_ms,
	output logic out_valid,
	input wire logic out_ready,
	output logic bit_value,
	output logic digit_done,
	output logic digit_valid,
	output logic [3:0] digit_value,
	output logic sum_done,
	output logic [4:0] pair_sum
);
	import opwbr_pkg::*;

	cfg_t cfg_q;
	queue_stat_t qstat;
	logic push;
	logic push_bit;
	logic pop;
	logic pop_bit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dark_threshold <= RESET_DARK_THRESHOLD;
			cfg_q.min_pulse_ms <= RESET_MIN_PULSE;
			cfg_q.bit_boundary_ms <= RESET_BIT_BOUNDARY;
			cfg_q.max_pulse_ms <= RESET_MAX_PULSE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DARK_THRESHOLD: cfg_q.dark_threshold <= cfg_data[9:0];
				REG_MIN_PULSE: cfg_q.min_pulse_ms <= cfg_data;
				REG_BIT_BOUNDARY: cfg_q.bit_boundary_ms <= cfg_data;
				REG_MAX_PULSE: cfg_q.max_pulse_ms <= cfg_data;
				default: ;
			endcase
		end
	end

	opwbr_front #(
		.TIME_BITS(TIME_BITS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_level(sample_level),
		.time_ms(time_ms),
		.qstat(qstat),
		.push(push),
		.push_bit(push_bit)
	);

	opwbr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_bit(push_bit),
		.pop(pop),
		.pop_bit(pop_bit),
		.qstat(qstat)
	);

	opwbr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.qstat(qstat),
		.pop_bit(pop_bit),
		.pop(pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.bit_value(bit_value),
		.digit_done(digit_done),
		.digit_valid(digit_valid),
		.digit_value(digit_value),
		.sum_done(sum_done),
		.pair_sum(pair_sum)
	);

endmodule

`default_nettype wire

// ----- rtl/opwbr_checker.sv -----
`default_nettype none

module opwbr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic bit_value,
	input wire logic digit_done,
	input wire logic digit_valid,
	input wire logic [3:0] digit_value,
	input wire logic sum_done,
	input wire logic [4:0] pair_sum
);

	// A stalled result must hold until its transfer.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(bit_value) &&
		$stable(digit_done) && $stable(digit_valid) && $stable(digit_value) &&
		$stable(sum_done) && $stable(pair_sum))
		else $error("result changed while stalled");

	a_mid_group: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !digit_done |-> !digit_valid && digit_value == 4'd0 &&
		!sum_done && pair_sum == 5'd0)
		else $error("digit fields set on a bit that ends no group");

	a_sum_needs_digit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sum_done |-> digit_done && digit_valid && pair_sum <= 5'd18)
		else $error("pair sum without a valid completed digit");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && digit_valid |-> digit_value <= 4'd9)
		else $error("valid digit out of BCD range");

endmodule

bind optical_pulse_width_bcd_receiver opwbr_checker u_opwbr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.bit_value(bit_value),
	.digit_done(digit_done),
	.digit_valid(digit_valid),
	.digit_value(digit_value),
	.sum_done(sum_done),
	.pair_sum(pair_sum)
);

`default_nettype wire
